FILE: rtl/core/sst_pkg.sv
// ============================================================================
// sst_pkg
// Shared widths, CORDIC arc tangent table and result codes for the sunrise
// and sunset time pipeline.
// ============================================================================
`default_nettype none

package sst_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int DIV_STEPS    = 31;
    localparam int SQRT_STEPS   = 31;

    localparam int XW  = 34;    // CORDIC vector components, Q30 with headroom
    localparam int ZW  = 26;    // angles in 1/65536 degree
    localparam int RW  = 32;    // divider remainder and divisor
    localparam int QW  = 31;    // divider quotient, Q30 up to one
    localparam int SW  = 62;    // square root radicand and root

    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
        26'sd117305,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
        26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
        26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7
    };

    localparam logic [1:0] STATUS_NORMAL  = 2'd0;
    localparam logic [1:0] STATUS_NO_RISE = 2'd1;
    localparam logic [1:0] STATUS_NO_SET  = 2'd2;

    localparam logic [1:0] REG_LATITUDE  = 2'd0;
    localparam logic [1:0] REG_LONGITUDE = 2'd1;
    localparam logic [1:0] REG_ZONE      = 2'd2;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 flip;
    } fold_t;

endpackage

`default_nettype wire

FILE: rtl/core/sst_rot_cell.sv
// ============================================================================
// sst_rot_cell
// One rotation step of a pipelined CORDIC sine and cosine chain.
// ============================================================================
`default_nettype none

module sst_rot_cell #(
    parameter int STEP = 0
) (
    input  wire                               clk,
    input  wire                               en,
    input  wire logic signed [sst_pkg::XW-1:0] x_in,
    input  wire logic signed [sst_pkg::XW-1:0] y_in,
    input  wire logic signed [sst_pkg::ZW-1:0] z_in,
    input  wire logic                          flip_in,
    output logic signed [sst_pkg::XW-1:0]      x_out,
    output logic signed [sst_pkg::XW-1:0]      y_out,
    output logic signed [sst_pkg::ZW-1:0]      z_out,
    output logic                               flip_out
);
    import sst_pkg::*;

    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    // rotate towards zero residual angle
    always_comb
    begin
        if (z_in >= 0)
        begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - ATAN_TAB[STEP];
        end
        else
        begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_out    <= x_next;
            y_out    <= y_next;
            z_out    <= z_next;
            flip_out <= flip_in;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sst_vec_cell.sv
// ============================================================================
// sst_vec_cell
// One vectoring step of the pipelined CORDIC arc cosine chain.
// ============================================================================
`default_nettype none

module sst_vec_cell #(
    parameter int STEP = 0
) (
    input  wire                               clk,
    input  wire                               en,
    input  wire logic signed [sst_pkg::XW-1:0] x_in,
    input  wire logic signed [sst_pkg::XW-1:0] y_in,
    input  wire logic signed [sst_pkg::ZW-1:0] z_in,
    output logic signed [sst_pkg::XW-1:0]      x_out,
    output logic signed [sst_pkg::XW-1:0]      y_out,
    output logic signed [sst_pkg::ZW-1:0]      z_out
);
    import sst_pkg::*;

    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    // drive y towards zero, accumulate the angle
    always_comb
    begin
        if (y_in > 0)
        begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + ATAN_TAB[STEP];
        end
        else
        begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_out <= x_next;
            y_out <= y_next;
            z_out <= z_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sst_sqrt_cell.sv
// ============================================================================
// sst_sqrt_cell
// One digit step of the pipelined integer square root.
// ============================================================================
`default_nettype none

module sst_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire                       clk,
    input  wire                       en,
    input  wire logic [sst_pkg::SW-1:0] v_in,
    input  wire logic [sst_pkg::SW-1:0] res_in,
    output logic [sst_pkg::SW-1:0]      v_out,
    output logic [sst_pkg::SW-1:0]      res_out
);
    import sst_pkg::*;

    localparam logic [SW-1:0] BIT = SW'(1) << (2 * STEP);

    logic [SW-1:0] trial;
    logic [SW-1:0] v_next;
    logic [SW-1:0] res_next;

    always_comb
    begin
        trial = res_in + BIT;
        if (v_in >= trial)
        begin
            v_next   = v_in - trial;
            res_next = (res_in >> 1) + BIT;
        end
        else
        begin
            v_next   = v_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_out   <= v_next;
            res_out <= res_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sst_div_cell.sv
// ============================================================================
// sst_div_cell
// One quotient bit of the pipelined restoring divider.
// ============================================================================
`default_nettype none

module sst_div_cell (
    input  wire                       clk,
    input  wire                       en,
    input  wire logic [sst_pkg::RW-1:0] r_in,
    input  wire logic [sst_pkg::RW-1:0] den_in,
    input  wire logic [sst_pkg::QW-1:0] q_in,
    output logic [sst_pkg::RW-1:0]      r_out,
    output logic [sst_pkg::RW-1:0]      den_out,
    output logic [sst_pkg::QW-1:0]      q_out
);
    import sst_pkg::*;

    logic          take;
    logic [RW-1:0] diff;

    // compare, subtract, then shift for the next bit
    always_comb
    begin
        take = (r_in >= den_in);
        diff = take ? (r_in - den_in) : r_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_out   <= {diff[RW-2:0], 1'b0};
            den_out <= den_in;
            q_out   <= {q_in[QW-2:0], take};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sunrise_sunset_time.sv
// ============================================================================
// sunrise_sunset_time
// Sunrise and sunset clock times for a configured site, one day per cycle unless held.
// ============================================================================
// Usage:
//   Program latitude, longitude (west positive, 1/256 degree) and zone offset
//   (quarter hours) through the APB port at byte addresses 0, 4 and 8; writes
//   saturate to the legal range and reads return the stored value.
//   Offer day numbers on in_valid/day_number; a transaction is taken when
//   in_valid is high and in_stall low. Each day yields one result transaction
//   on out_valid with rise/set hour and minute plus sun_status.
//   Throughput is one transaction per cycle while the pipeline is not held,
//   set by the fully pipelined CORDIC rotation and vectoring (20 cells each),
//   divider (31 cells) and square-root (31 cells) chains.
//   While out_valid is high and out_stall is high the whole pipeline holds
//   and in_stall is raised in the same cycle; otherwise input is always taken.
//   Reset clears the site registers to zero and empties the pipeline.
//   Polar day, polar night and the pole give a non-zero sun_status and zero
//   time fields.
// ============================================================================
`default_nettype none

module sunrise_sunset_time (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire        [3:0]  paddr,
    input  wire        [31:0] pwdata,
    output logic       [31:0] prdata,
    output logic              pready,
    input  wire               in_valid,
    output logic              in_stall,
    input  wire        [8:0]  day_number,
    output logic              out_valid,
    input  wire               out_stall,
    output logic signed [6:0] rise_hour,
    output logic       [5:0]  rise_minute,
    output logic signed [6:0] set_hour,
    output logic       [5:0]  set_minute,
    output logic       [1:0]  sun_status
);
    import sst_pkg::*;

    localparam int C = CORDIC_STEPS;
    localparam int D = DIV_STEPS;
    localparam int Q = SQRT_STEPS;

    // stage numbers, counted from the input register as stage 1
    localparam int S_FOLD  = 4;
    localparam int S_PROD1 = S_FOLD + C + 1;
    localparam int S_SUM   = S_PROD1 + 1;
    localparam int S_EQ    = S_SUM + 1;
    localparam int S_BASE  = S_EQ + 1;
    localparam int S_PROD2 = S_EQ + C + 1;
    localparam int S_ND    = S_PROD2 + 1;
    localparam int S_V     = S_ND + D + 1;
    localparam int S_VEC   = S_V + Q + C;
    localparam int S_T     = S_VEC + 1;
    localparam int S_X     = S_T + 1;
    localparam int S_OUT   = S_X + 1;

    localparam int BASE_LEN = S_VEC - S_BASE + 1;
    localparam int STAT_LEN = S_X - S_ND + 1;
    localparam int NNEG_LEN = D + 1;
    localparam int AC_LEN   = Q + 1;
    localparam int NEG_LEN  = Q + C + 1;

    localparam logic [26:0] TURN = 27'd23592960;
    localparam logic [26:0] HALF = 27'd11796480;
    localparam logic signed [ZW-1:0] QTR_S  = 26'sd5898240;
    localparam logic signed [ZW-1:0] HALF_S = 26'sd11796480;
    localparam logic signed [XW-1:0] X_INIT = 34'sd652032874;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] site_latitude_reg;
    logic signed [16:0] site_longitude_reg;
    logic signed [6:0]  zone_offset_reg;
    logic               cfg_write;
    logic signed [15:0] lat_wr;
    logic signed [16:0] lon_wr;
    logic signed [6:0]  zone_wr;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    // saturate written values to the legal range
    always_comb
    begin
        lat_wr  = $signed(pwdata[15:0]);
        lon_wr  = $signed(pwdata[16:0]);
        zone_wr = $signed(pwdata[6:0]);
        if (lat_wr > 16'sd23040)
        begin
            lat_wr = 16'sd23040;
        end
        else if (lat_wr < -16'sd23040)
        begin
            lat_wr = -16'sd23040;
        end
        if (lon_wr > 17'sd46080)
        begin
            lon_wr = 17'sd46080;
        end
        else if (lon_wr < -17'sd46080)
        begin
            lon_wr = -17'sd46080;
        end
        if (zone_wr > 7'sd56)
        begin
            zone_wr = 7'sd56;
        end
        else if (zone_wr < -7'sd56)
        begin
            zone_wr = -7'sd56;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_latitude_reg  <= '0;
            site_longitude_reg <= '0;
            zone_offset_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_LATITUDE:  site_latitude_reg  <= lat_wr;
                REG_LONGITUDE: site_longitude_reg <= lon_wr;
                REG_ZONE:      zone_offset_reg    <= zone_wr;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LATITUDE:  prdata = 32'(site_latitude_reg);
            REG_LONGITUDE: prdata = 32'(site_longitude_reg);
            REG_ZONE:      prdata = 32'(zone_offset_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline advances unless a result is stuck
    // ------------------------------------------------------------------
    logic adv;
    logic vld_reg [S_OUT];

    assign adv       = !(vld_reg[S_OUT-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[S_OUT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < S_OUT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < S_OUT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    function automatic logic signed [31:0] qmul(input logic signed [XW-1:0] a,
                                                input logic signed [31:0]   b);
        logic signed [XW+31:0] p;
        p = a * b;
        return p[61:30];
    endfunction

    function automatic fold_t fold(input logic [26:0] a);
        fold_t                f;
        logic signed [ZW-1:0] s;
        s = (a >= HALF) ? $signed(ZW'(a)) - $signed(ZW'(TURN)) : $signed(ZW'(a));
        f.flip = 1'b0;
        f.z    = s;
        if (s > QTR_S)
        begin
            f.z    = s - HALF_S;
            f.flip = 1'b1;
        end
        else if (s < -QTR_S)
        begin
            f.z    = s + HALF_S;
            f.flip = 1'b1;
        end
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Stages 1 to 3: fractional-year angle, (day-1) mod 365 scaled to a turn
    // ------------------------------------------------------------------
    logic [8:0]  n1_reg;
    logic [8:0]  n1_next;
    logic [9:0]  t1;
    logic [8:0]  n2_reg;
    logic [15:0] x2_reg;
    logic [15:0] x2_next;
    logic [27:0] p2;
    logic [6:0]  q2_reg;
    logic [24:0] lam3_reg;
    logic [24:0] lam3_next;

    always_comb
    begin
        t1 = {1'b0, day_number} + 10'd364;
        if (t1 >= 10'd730)
        begin
            n1_next = 9'(t1 - 10'd730);
        end
        else if (t1 >= 10'd365)
        begin
            n1_next = 9'(t1 - 10'd365);
        end
        else
        begin
            n1_next = t1[8:0];
        end
        // remainder part of n*TURN/365, quotient by reciprocal
        x2_next   = 16'(n1_reg) * 16'd90 + 16'd182;
        p2        = 28'(x2_next) * 28'd2873;
        lam3_next = 25'(n2_reg) * 25'd64638 + 25'(q2_reg)
                  - 25'((16'(q2_reg) * 16'd365) > x2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_reg   <= n1_next;
            n2_reg   <= n1_reg;
            x2_reg   <= x2_next;
            q2_reg   <= p2[26:20];
            lam3_reg <= lam3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: one, two and three times the angle, folded into half a turn
    // ------------------------------------------------------------------
    fold_t       fold_reg [3];
    logic [26:0] ang2;
    logic [26:0] ang3;

    always_comb
    begin
        ang2 = {1'b0, lam3_reg, 1'b0};
        if (ang2 >= TURN)
        begin
            ang2 = ang2 - TURN;
        end
        ang3 = 27'(lam3_reg) * 27'd3;
        if (ang3 >= {TURN[25:0], 1'b0})
        begin
            ang3 = ang3 - {TURN[25:0], 1'b0};
        end
        else if (ang3 >= TURN)
        begin
            ang3 = ang3 - TURN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fold_reg[0] <= fold(27'(lam3_reg));
            fold_reg[1] <= fold(ang2);
            fold_reg[2] <= fold(ang3);
        end
    end

    // ------------------------------------------------------------------
    // First CORDIC row: sine and cosine of the three harmonics
    // ------------------------------------------------------------------
    logic signed [XW-1:0] h_x [3][C+1];
    logic signed [XW-1:0] h_y [3][C+1];
    logic signed [ZW-1:0] h_z [3][C+1];
    logic                 h_f [3][C+1];

    for (genvar a = 0; a < 3; a++)
    begin : g_harm
        assign h_x[a][0] = X_INIT;
        assign h_y[a][0] = '0;
        assign h_z[a][0] = fold_reg[a].z;
        assign h_f[a][0] = fold_reg[a].flip;
        for (genvar i = 0; i < C; i++)
        begin : g_cell
            sst_rot_cell #(.STEP(i)) u_cell (
                .clk      (clk),
                .en       (adv),
                .x_in     (h_x[a][i]),
                .y_in     (h_y[a][i]),
                .z_in     (h_z[a][i]),
                .flip_in  (h_f[a][i]),
                .x_out    (h_x[a][i+1]),
                .y_out    (h_y[a][i+1]),
                .z_out    (h_z[a][i+1]),
                .flip_out (h_f[a][i+1])
            );
        end
    end

    // ------------------------------------------------------------------
    // Fourier series for equation of time and declination
    // ------------------------------------------------------------------
    logic signed [XW-1:0] hs [3];
    logic signed [XW-1:0] hc [3];
    logic signed [31:0]   eqt_reg [4];
    logic signed [31:0]   dct_reg [6];
    logic signed [31:0]   eq_sum_reg;
    logic signed [31:0]   decl_sum_reg;
    logic signed [31:0]   eq_reg;
    logic signed [31:0]   decl_full;
    logic signed [ZW-1:0] decl_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            hs[a] = h_f[a][C] ? -h_y[a][C] : h_y[a][C];
            hc[a] = h_f[a][C] ? -h_x[a][C] : h_x[a][C];
        end
        decl_full = qmul(34'(decl_sum_reg), 32'sd3754937);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            eqt_reg[0] <= qmul(hc[0], 32'sd2005750);
            eqt_reg[1] <= qmul(hs[0], 32'sd34442416);
            eqt_reg[2] <= qmul(hc[1], 32'sd15692737);
            eqt_reg[3] <= qmul(hs[1], 32'sd43861280);
            dct_reg[0] <= qmul(hc[0], 32'sd429402240);
            dct_reg[1] <= qmul(hs[0], 32'sd75437879);
            dct_reg[2] <= qmul(hc[1], 32'sd7256347);
            dct_reg[3] <= qmul(hs[1], 32'sd973884);
            dct_reg[4] <= qmul(hc[2], 32'sd2895882);
            dct_reg[5] <= qmul(hs[2], 32'sd1589138);
            eq_sum_reg <= 32'sd80531 + eqt_reg[0] - eqt_reg[1]
                        - eqt_reg[2] - eqt_reg[3];
            decl_sum_reg <= 32'sd7428146 - dct_reg[0] + dct_reg[1] - dct_reg[2]
                          + dct_reg[3] - dct_reg[4] + dct_reg[5];
            eq_reg   <= qmul(34'(eq_sum_reg), 32'sd15019540);
            decl_reg <= decl_full[ZW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Second CORDIC row: declination (row 0) and site latitude (row 1)
    // ------------------------------------------------------------------
    logic signed [XW-1:0] g_x [2][C+1];
    logic signed [XW-1:0] g_y [2][C+1];
    logic signed [ZW-1:0] g_z [2][C+1];
    logic                 g_f [2][C+1];

    assign g_z[0][0] = decl_reg;
    assign g_z[1][0] = ZW'($signed({site_latitude_reg, 8'd0}));

    for (genvar a = 0; a < 2; a++)
    begin : g_site
        assign g_x[a][0] = X_INIT;
        assign g_y[a][0] = '0;
        assign g_f[a][0] = 1'b0;
        for (genvar i = 0; i < C; i++)
        begin : g_cell
            sst_rot_cell #(.STEP(i)) u_cell (
                .clk      (clk),
                .en       (adv),
                .x_in     (g_x[a][i]),
                .y_in     (g_y[a][i]),
                .z_in     (g_z[a][i]),
                .flip_in  (g_f[a][i]),
                .x_out    (g_x[a][i+1]),
                .y_out    (g_y[a][i+1]),
                .z_out    (g_z[a][i+1]),
                .flip_out (g_f[a][i+1])
            );
        end
    end

    // clock-time offset shared by both events, in 1/65536 minute
    logic signed [31:0] base_dly_reg [BASE_LEN];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            base_dly_reg[0] <= 32'sd47185920
                             + 32'($signed({site_longitude_reg, 10'd0}))
                             - eq_reg - 32'(zone_offset_reg) * 32'sd983040;
            for (int i = 1; i < BASE_LEN; i++)
            begin
                base_dly_reg[i] <= base_dly_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Zenith expression: numerator, denominator and polar status
    // ------------------------------------------------------------------
    logic signed [31:0] slsd_reg;
    logic signed [31:0] clcd_reg;
    logic signed [33:0] num;
    logic [1:0]         status_next;
    logic [RW-1:0]      nabs_reg;
    logic [RW-1:0]      den_reg;
    logic [1:0]         stat_dly_reg [STAT_LEN];
    logic               nneg_dly_reg [NNEG_LEN];

    always_comb
    begin
        num = -34'sd15572649 - 34'(slsd_reg);
        if (clcd_reg <= 0)
        begin
            status_next = (num > 0) ? STATUS_NO_RISE : STATUS_NO_SET;
        end
        else if (num > 34'(clcd_reg))
        begin
            status_next = STATUS_NO_RISE;
        end
        else if (num < -34'(clcd_reg))
        begin
            status_next = STATUS_NO_SET;
        end
        else
        begin
            status_next = STATUS_NORMAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            slsd_reg <= qmul(g_y[1][C], 32'(g_y[0][C]));
            clcd_reg <= qmul(g_x[1][C], 32'(g_x[0][C]));
            nabs_reg <= RW'((num < 0) ? -num : num);
            den_reg  <= RW'(clcd_reg);
            stat_dly_reg[0] <= status_next;
            nneg_dly_reg[0] <= (num < 0);
            for (int i = 1; i < STAT_LEN; i++)
            begin
                stat_dly_reg[i] <= stat_dly_reg[i-1];
            end
            for (int i = 1; i < NNEG_LEN; i++)
            begin
                nneg_dly_reg[i] <= nneg_dly_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider row: |num| * 2^30 / den, one quotient bit per cell
    // ------------------------------------------------------------------
    logic [RW-1:0] d_r [D+1];
    logic [RW-1:0] d_d [D+1];
    logic [QW-1:0] d_q [D+1];

    assign d_r[0] = nabs_reg;
    assign d_d[0] = den_reg;
    assign d_q[0] = '0;

    for (genvar i = 0; i < D; i++)
    begin : g_div
        sst_div_cell u_cell (
            .clk     (clk),
            .en      (adv),
            .r_in    (d_r[i]),
            .den_in  (d_d[i]),
            .q_in    (d_q[i]),
            .r_out   (d_r[i+1]),
            .den_out (d_d[i+1]),
            .q_out   (d_q[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Sine of the hour angle by square root of one minus cosine squared
    // ------------------------------------------------------------------
    logic [SW-1:0] v_reg;
    logic [QW-1:0] ac_dly_reg [AC_LEN];
    logic          neg_dly_reg [NEG_LEN];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg          <= (SW'(1) << 60) - SW'(d_q[D]) * SW'(d_q[D]);
            ac_dly_reg[0]  <= d_q[D];
            neg_dly_reg[0] <= nneg_dly_reg[NNEG_LEN-1] && (d_q[D] != '0);
            for (int i = 1; i < AC_LEN; i++)
            begin
                ac_dly_reg[i] <= ac_dly_reg[i-1];
            end
            for (int i = 1; i < NEG_LEN; i++)
            begin
                neg_dly_reg[i] <= neg_dly_reg[i-1];
            end
        end
    end

    logic [SW-1:0] r_v   [Q+1];
    logic [SW-1:0] r_res [Q+1];

    assign r_v[0]   = v_reg;
    assign r_res[0] = '0;

    for (genvar i = 0; i < Q; i++)
    begin : g_sqrt
        sst_sqrt_cell #(.STEP(Q - 1 - i)) u_cell (
            .clk     (clk),
            .en      (adv),
            .v_in    (r_v[i]),
            .res_in  (r_res[i]),
            .v_out   (r_v[i+1]),
            .res_out (r_res[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Vectoring row: arc tangent of sine over |cosine|
    // ------------------------------------------------------------------
    logic signed [XW-1:0] v_x [C+1];
    logic signed [XW-1:0] v_y [C+1];
    logic signed [ZW-1:0] v_z [C+1];

    assign v_x[0] = $signed(XW'(ac_dly_reg[AC_LEN-1]));
    assign v_y[0] = $signed(XW'(r_res[Q]));
    assign v_z[0] = '0;

    for (genvar i = 0; i < C; i++)
    begin : g_vec
        sst_vec_cell #(.STEP(i)) u_cell (
            .clk   (clk),
            .en    (adv),
            .x_in  (v_x[i]),
            .y_in  (v_y[i]),
            .z_in  (v_z[i]),
            .x_out (v_x[i+1]),
            .y_out (v_y[i+1]),
            .z_out (v_z[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Event times, whole minutes, and split into hour and minute
    // ------------------------------------------------------------------
    logic signed [ZW-1:0] ha;
    logic signed [31:0]   ha4;
    logic signed [31:0]   rise_t;
    logic signed [31:0]   set_t;
    logic signed [12:0]   rise_m_reg;
    logic signed [12:0]   set_m_reg;
    logic [13:0]          rise_x_reg;
    logic [13:0]          set_x_reg;
    logic [13:0]          rise_x_next;
    logic [13:0]          set_x_next;
    logic [23:0]          rise_p;
    logic [23:0]          set_p;
    logic [7:0]           rise_q0_reg;
    logic [7:0]           set_q0_reg;
    logic [7:0]           rise_q;
    logic [7:0]           set_q;

    always_comb
    begin
        // clamp to a quarter turn, mirror for a negative cosine
        ha = v_z[C];
        if (ha < 0)
        begin
            ha = '0;
        end
        else if (ha > QTR_S)
        begin
            ha = QTR_S;
        end
        if (neg_dly_reg[NEG_LEN-1])
        begin
            ha = HALF_S - ha;
        end
        ha4    = 32'(ha) <<< 2;
        rise_t = base_dly_reg[BASE_LEN-1] - ha4;
        set_t  = base_dly_reg[BASE_LEN-1] + ha4;
        // offset by a whole number of hours to floor by 60 as unsigned
        rise_x_next = 14'(rise_m_reg) + 14'd4200;
        set_x_next  = 14'(set_m_reg) + 14'd4200;
        rise_p      = 24'(rise_x_next) * 24'd1093;
        set_p       = 24'(set_x_next) * 24'd1093;
        rise_q      = rise_q0_reg - 8'((14'(rise_q0_reg) * 14'd60) > rise_x_reg);
        set_q       = set_q0_reg - 8'((14'(set_q0_reg) * 14'd60) > set_x_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rise_m_reg  <= rise_t[28:16];
            set_m_reg   <= set_t[28:16];
            rise_x_reg  <= rise_x_next;
            set_x_reg   <= set_x_next;
            rise_q0_reg <= rise_p[23:16];
            set_q0_reg  <= set_p[23:16];
            sun_status  <= stat_dly_reg[STAT_LEN-1];
            if (stat_dly_reg[STAT_LEN-1] == STATUS_NORMAL)
            begin
                rise_hour   <= $signed(7'(rise_q - 8'd70));
                rise_minute <= 6'(rise_x_reg - 14'(rise_q) * 14'd60);
                set_hour    <= $signed(7'(set_q - 8'd70));
                set_minute  <= 6'(set_x_reg - 14'(set_q) * 14'd60);
            end
            else
            begin
                rise_hour   <= '0;
                rise_minute <= '0;
                set_hour    <= '0;
                set_minute  <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while a result is held");

    a_polar_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sun_status != STATUS_NORMAL) |->
        (rise_hour == 7'sd0 && rise_minute == 6'd0 && set_hour == 7'sd0
         && set_minute == 6'd0))
        else $error("polar result carries non-zero times");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sun_status == STATUS_NORMAL || sun_status == STATUS_NO_RISE
                       || sun_status == STATUS_NO_SET))
        else $error("unknown sun status");

    a_minute_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rise_minute < 6'd60 && set_minute < 6'd60))
        else $error("minute out of range");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Sunrise and sunset time block testbench
// Programs a series of sites through the APB port, from the reset site to the
// poles, the date line and the widest zone offsets, and streams day numbers
// through the pipeline. Each result is checked field by field against an
// in-bench fixed point predictor of the CORDIC, arc cosine and time maths.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam longint DEG    = 65536;
    localparam longint TURN   = 360 * DEG;
    localparam longint Q30    = 1073741824;
    localparam int     LIMIT  = 400000;
    localparam int     NPHASE = 8;

    typedef struct {
        logic signed [6:0] rise_hour;
        logic        [5:0] rise_minute;
        logic signed [6:0] set_hour;
        logic        [5:0] set_minute;
        logic        [1:0] sun_status;
    } sun_times_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [8:0]  day_number;
    logic        out_valid;
    logic        out_stall;
    logic signed [6:0] rise_hour;
    logic [5:0]  rise_minute;
    logic signed [6:0] set_hour;
    logic [5:0]  set_minute;
    logic [1:0]  sun_status;

    // site shadow, as the block holds it after saturation
    longint site_lat;
    longint site_lon;
    longint site_zone;

    logic [8:0]  days_pending[$];
    sun_times_t  times_due[$];
    int          errors;
    int          cycles;
    int          days_sent;
    int          results_seen;
    int          polar_seen;
    bit          day_taken;
    int          burst_left;
    int          gap_left;
    int          stall_mode;

    sunrise_sunset_time dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .day_number(day_number),
        .out_valid(out_valid), .out_stall(out_stall),
        .rise_hour(rise_hour), .rise_minute(rise_minute),
        .set_hour(set_hour), .set_minute(set_minute), .sun_status(sun_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- maths
    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // CORDIC rotation; fold the angle into -90..90 degrees first
    function automatic void sin_cos(input longint a, output longint s, output longint c);
        longint x, y, z, dx, dy;
        bit     flip;
        x = 652032874;
        y = 0;
        flip = 0;
        a = a % TURN;
        if (a < 0)
            a = a + TURN;
        if (a >= TURN / 2)
            a = a - TURN;
        if (a > 90 * DEG)
        begin
            a = a - 180 * DEG;
            flip = 1;
        end
        else if (a < -90 * DEG)
        begin
            a = a + 180 * DEG;
            flip = 1;
        end
        z = a;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    // arc cosine of a Q30 value, answer in 1/65536 degree
    function automatic longint arc_cos(input longint c);
        longint ac, x, y, z, dx, dy;
        longint unsigned v, root, bitv;
        ac = c < 0 ? -c : c;
        v = longint'(Q30 * Q30 - ac * ac);
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        x = ac;
        y = longint'(root);
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
            end
        end
        z = clip(z, 0, 90 * DEG);
        return c < 0 ? 180 * DEG - z : z;
    endfunction

    function automatic sun_times_t predict_sun_times(input logic [8:0] day);
        sun_times_t r;
        longint n, lam, s1, c1, s2, c2, s3, c3, sl, cl, sd, cd;
        longint eqt, decl, num, den, ha, rise, set, m, h;
        logic [1:0] st;
        // day 0 wraps to 365, day 366 and beyond wrap round the year
        n = (longint'(day) + 364) % 365;
        lam = (n * TURN + 182) / 365;
        sin_cos(lam, s1, c1);
        sin_cos(2 * lam, s2, c2);
        sin_cos(3 * lam, s3, c3);
        eqt = 80531 + qmul(2005750, c1) - qmul(34442416, s1)
            - qmul(15692737, c2) - qmul(43861280, s2);
        eqt = (eqt * 15019540) >>> 30;
        decl = 7428146 - qmul(429402240, c1) + qmul(75437879, s1)
             - qmul(7256347, c2) + qmul(973884, s2)
             - qmul(2895882, c3) + qmul(1589138, s3);
        decl = (decl * 3754937) >>> 30;
        sin_cos(site_lat * 256, sl, cl);
        sin_cos(decl, sd, cd);
        num = -15572649 - qmul(sl, sd);
        den = qmul(cl, cd);
        st = STATUS_NORMAL;
        if (den <= 0)
            st = num > 0 ? STATUS_NO_RISE : STATUS_NO_SET;
        else if (num > den)
            st = STATUS_NO_RISE;
        else if (num < -den)
            st = STATUS_NO_SET;
        r.rise_hour = '0;
        r.rise_minute = '0;
        r.set_hour = '0;
        r.set_minute = '0;
        r.sun_status = st;
        if (st == STATUS_NORMAL)
        begin
            ha = arc_cos(clip((num * Q30) / den, -Q30, Q30));
            rise = 720 * DEG + 4 * (site_lon * 256 - ha) - eqt - site_zone * 15 * DEG;
            set  = 720 * DEG + 4 * (site_lon * 256 + ha) - eqt - site_zone * 15 * DEG;
            m = floor_div(rise, DEG);
            h = floor_div(m, 60);
            r.rise_hour = h[6:0];
            r.rise_minute = 6'(m - 60 * h);
            m = floor_div(set, DEG);
            h = floor_div(m, 60);
            r.set_hour = h[6:0];
            r.set_minute = 6'(m - 60 * h);
        end
        return r;
    endfunction

    // ------------------------------------------------------- config access
    // setup cycle then access cycle; shadow follows the block's saturation
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_LATITUDE:  site_lat  = clip(longint'(signed'(value[15:0])), -23040, 23040);
            REG_LONGITUDE: site_lon  = clip(longint'(signed'(value[16:0])), -46080, 46080);
            REG_ZONE:      site_zone = clip(longint'(signed'(value[6:0])), -56, 56);
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- driver
    // Work in bursts: hold a stalled transaction, otherwise advance the queue
    // or sit out a gap.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !day_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (days_pending.size() > 0)
            begin
                in_valid <= 1'b1;
                day_number <= days_pending.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: drive out_stall from one of four randomly chosen patterns
    always @(negedge clk)
    begin
        if (cycles % 256 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (cycles % 11) < 4;
        endcase
    end

    // --------------------------------------------------------------- monitor
    always @(posedge clk)
    begin
        sun_times_t want;
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, times_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        day_taken = in_valid && !in_stall;
        if (rst_n && day_taken)
        begin
            times_due.push_back(predict_sun_times(day_number));
            days_sent++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (times_due.size() == 0)
            begin
                $display("%0t: result with nothing expected: %0d:%0d %0d:%0d st %0d", $time,
                         rise_hour, rise_minute, set_hour, set_minute, sun_status);
                errors++;
            end
            else
            begin
                want = times_due.pop_front();
                if (want.sun_status != STATUS_NORMAL)
                    polar_seen++;
                if (rise_hour !== want.rise_hour)
                begin
                    $display("%0t: rise_hour expected %0d got %0d", $time,
                             want.rise_hour, rise_hour);
                    errors++;
                end
                if (rise_minute !== want.rise_minute)
                begin
                    $display("%0t: rise_minute expected %0d got %0d", $time,
                             want.rise_minute, rise_minute);
                    errors++;
                end
                if (set_hour !== want.set_hour)
                begin
                    $display("%0t: set_hour expected %0d got %0d", $time,
                             want.set_hour, set_hour);
                    errors++;
                end
                if (set_minute !== want.set_minute)
                begin
                    $display("%0t: set_minute expected %0d got %0d", $time,
                             want.set_minute, set_minute);
                    errors++;
                end
                if (sun_status !== want.sun_status)
                begin
                    $display("%0t: sun_status expected %0d got %0d", $time,
                             want.sun_status, sun_status);
                    errors++;
                end
            end
        end
    end

    // -------------------------------------------------------------- sequence
    task automatic drain();
        while (days_pending.size() > 0 || in_valid || times_due.size() > 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] lat_set [NPHASE];
        logic [31:0] lon_set [NPHASE];
        logic [31:0] zone_set [NPHASE];
        logic [8:0]  day;
        // latitude, longitude and zone per phase; phases 5 and 6 saturate on write
        lat_set  = '{0, 23040, -23040, 17920, -17152, 32'h0000_7FFF, 32'h0000_8000, 10240};
        lon_set  = '{0, 46080, -46080, 19200, -30000, 32'h0000_FFFF, 32'h0001_0000, -1};
        zone_set = '{0, 56, -56, 20, -32, 32'h0000_003F, 32'h0000_0040, 32'hFFFF_FFC8};
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; day_number = '0; out_stall = 1'b0;
        site_lat = 0; site_lon = 0; site_zone = 0;
        errors = 0; cycles = 0; days_sent = 0; results_seen = 0; polar_seen = 0;
        day_taken = 0; burst_left = 1; gap_left = 0; stall_mode = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first three sites: year ends, wraps, solstices, equinox, all-ones day
        foreach (lat_set[p])
        begin
            if (p > 0)
            begin
                apb_write(REG_LATITUDE, lat_set[p]);
                apb_write(REG_LONGITUDE, lon_set[p]);
                apb_write(REG_ZONE, zone_set[p]);
            end
            if (p == 0 || p == 1)
                foreach (days_pending[i]) ;
            if (p < 3)
            begin
                days_pending.push_back(9'd0);
                days_pending.push_back(9'd1);
                days_pending.push_back(9'd2);
                days_pending.push_back(9'd80);
                days_pending.push_back(9'd172);
                days_pending.push_back(9'd266);
                days_pending.push_back(9'd355);
                days_pending.push_back(9'd365);
                days_pending.push_back(9'd366);
                days_pending.push_back(9'd511);
                days_pending.push_back(9'd256);
            end
            for (int k = 0; k < 100; k++)
            begin
                day = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                  : 9'($urandom_range(1, 366));
                days_pending.push_back(day);
            end
            // sender stops here until the pipeline is empty
            drain();
        end

        $display("Checked %0d days over %0d site settings, %0d polar or pole results",
                 results_seen, NPHASE, polar_seen);
        if (errors == 0 && times_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
